FILE: rtl/lmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_pkg: shared types and constants for the level meter ballistics block
// Register index codes, the register file layout and reset values.
// ----------------------------------------------------------------------------
package lmb_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK = 3'd0,
		CFG_DECAY  = 3'd1,
		CFG_FLOOR  = 3'd2,
		CFG_HOLD   = 3'd3,
		CFG_FALL   = 3'd4
	} lmb_cfg_idx_t;

	typedef struct packed {
		logic        [15:0] attack_coeff;
		logic        [15:0] decay_coeff;
		logic signed [15:0] floor_level;
		logic        [7:0]  hold_ticks;
		logic        [11:0] fall_step;
	} lmb_cfg_t;

	localparam logic        [15:0] RST_ATTACK = 16'd26214;
	localparam logic        [15:0] RST_DECAY  = 16'd3277;
	localparam logic signed [15:0] RST_FLOOR  = -16'sd15360;
	localparam logic        [7:0]  RST_HOLD   = 8'd40;
	localparam logic        [11:0] RST_FALL   = 12'd128;

	// Floor reset value as an integer, for saturation at elaboration
	localparam int RST_FLOOR_INT = -15360;

	localparam logic [31:0] RST_SEQ = 32'hFFFF_FFFF;

endpackage

FILE: rtl/lmb_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_channel: one-pole ballistics and peak hold for one level channel
// Holds the smoothed level, the peak and the hold counter; presents the
// values they take after the current packet.
// ----------------------------------------------------------------------------
module lmb_channel #(
	parameter int LEVEL_WIDTH      = 16,
	parameter int HOLD_COUNT_WIDTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmb_pkg::lmb_cfg_t             cfg,
	input  logic                          upd,
	input  logic signed [LEVEL_WIDTH-1:0] level,
	output logic signed [LEVEL_WIDTH-1:0] next_avg,
	output logic signed [LEVEL_WIDTH-1:0] next_peak,
	output logic                          next_at_floor
);

	localparam int LW      = LEVEL_WIDTH;
	localparam int HCW     = HOLD_COUNT_WIDTH;
	localparam int LVL_MAX = (2 ** (LW - 1)) - 1;
	localparam int LVL_MIN = -(2 ** (LW - 1));
	localparam int FW      = (LW > 16) ? LW : 16;
	localparam int HW      = (HCW > 8) ? HCW : 8;
	localparam int PW      = LW + 2;
	localparam int RST_SAT = (lmb_pkg::RST_FLOOR_INT < LVL_MIN) ? LVL_MIN
		: lmb_pkg::RST_FLOOR_INT;
	localparam logic signed [LW-1:0] RST_LVL = RST_SAT[LW-1:0];

	logic signed [LW-1:0]  avg_q;
	logic signed [LW-1:0]  peak_q;
	logic        [HCW-1:0] hold_q;

	logic signed [FW-1:0]   floor_sx;
	logic signed [LW-1:0]   fl;
	logic        [HW-1:0]   ticks_x;
	logic        [HW-1:0]   maxh_x;
	logic        [HCW-1:0]  reload;
	logic signed [LW-1:0]   target;
	logic        [15:0]     coeff;
	logic signed [LW:0]     diff;
	logic signed [LW+17:0]  prod;
	logic signed [LW+2:0]   sum;
	logic signed [LW-1:0]   avg_new;
	logic signed [PW-1:0]   step_x;
	logic signed [PW-1:0]   peak_dec;
	logic signed [PW-1:0]   fl_x;
	logic signed [LW-1:0]   peak_new;
	logic        [HCW-1:0]  hold_new;

	// Clamp the floor into the level range
	always_comb begin
		floor_sx = FW'(cfg.floor_level);
		if (floor_sx > LVL_MAX) begin
			fl = LVL_MAX[LW-1:0];
		end else if (floor_sx < LVL_MIN) begin
			fl = LVL_MIN[LW-1:0];
		end else begin
			fl = floor_sx[LW-1:0];
		end
	end

	// Hold reload saturates at the counter's top value
	assign ticks_x = HW'(cfg.hold_ticks);
	assign maxh_x  = HW'({HCW{1'b1}});
	assign reload  = (ticks_x > maxh_x) ? {HCW{1'b1}} : ticks_x[HCW-1:0];

	assign target = (level < fl) ? fl : level;

	// One-pole smoothing; the arithmetic shift floors
	always_comb begin
		coeff = (target > avg_q) ? cfg.attack_coeff : cfg.decay_coeff;
		diff  = (LW+1)'(target) - (LW+1)'(avg_q);
		prod  = $signed(diff) * $signed({1'b0, coeff});
		sum   = (LW+3)'(avg_q) + (LW+3)'($signed(prod[LW+17:16]));
		if (sum > LVL_MAX) begin
			avg_new = LVL_MAX[LW-1:0];
		end else if (sum < LVL_MIN) begin
			avg_new = LVL_MIN[LW-1:0];
		end else begin
			avg_new = sum[LW-1:0];
		end
	end

	// Peak: reload on a new peak, else count down, then fall to the floor
	always_comb begin
		step_x   = PW'({1'b0, cfg.fall_step});
		fl_x     = PW'(fl);
		peak_dec = PW'(peak_q);
		hold_new = hold_q;
		peak_new = peak_q;
		if (target >= peak_q) begin
			peak_new = target;
			hold_new = reload;
		end else begin
			if (hold_q != '0) begin
				hold_new = hold_q - 1'b1;
			end else begin
				peak_dec = PW'(peak_q) - step_x;
			end
			if (peak_dec < fl_x) begin
				peak_new = fl;
			end else begin
				peak_new = peak_dec[LW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q  <= RST_LVL;
			peak_q <= RST_LVL;
			hold_q <= '0;
		end else if (upd) begin
			avg_q  <= avg_new;
			peak_q <= peak_new;
			hold_q <= hold_new;
		end
	end

	assign next_avg      = upd ? avg_new : avg_q;
	assign next_peak     = upd ? peak_new : peak_q;
	assign next_at_floor = (next_avg <= fl);

endmodule

FILE: rtl/level_meter_ballistics_peak_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_meter_ballistics_peak_hold: mid/side meter ballistics with peak hold
// Drops repeated packets, smooths each level one-pole and tracks held peaks.
// ----------------------------------------------------------------------------
// A packet is taken into an input register, and once the output register
// frees up both channels are updated and the result is written to the
// output register; one multiply per channel sets the path. The block
// accepts one packet per clock while in_stall is low, and a result is held
// back only while the output is stalled. A packet whose sequence number
// equals the last new one gives a result with accepted low and the current
// levels, and changes no state; after reset the sequence all ones counts as
// already seen. in_stall rises only while the output register holds a
// result that is stalled and the input register is full. Write configuration
// through cfg_valid/cfg_ready (always ready) only while no transaction is in
// flight; a floor outside the level range is clamped, and a hold count above
// the counter's top value saturates.
module level_meter_ballistics_peak_hold #(
	parameter int LEVEL_WIDTH      = 16,
	parameter int HOLD_COUNT_WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lmb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                       cfg_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       packet_seq,
	input  logic signed [LEVEL_WIDTH-1:0]     mid_level,
	input  logic signed [LEVEL_WIDTH-1:0]     side_level,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              accepted,
	output logic signed [LEVEL_WIDTH-1:0]     mid_smooth,
	output logic signed [LEVEL_WIDTH-1:0]     side_smooth,
	output logic signed [LEVEL_WIDTH-1:0]     mid_peak_out,
	output logic signed [LEVEL_WIDTH-1:0]     side_peak_out,
	output logic                              mid_at_floor,
	output logic                              side_at_floor
);

	lmb_pkg::lmb_cfg_t cfg_q;

	logic                          valid_s1;
	logic [31:0]                   packet_seq_s1;
	logic signed [LEVEL_WIDTH-1:0] mid_level_s1;
	logic signed [LEVEL_WIDTH-1:0] side_level_s1;

	logic [31:0] prev_seq_q;
	logic        out_valid_q;
	logic        adv;
	logic        take;
	logic        fresh;
	logic        upd;

	logic signed [LEVEL_WIDTH-1:0] mid_avg_nx;
	logic signed [LEVEL_WIDTH-1:0] side_avg_nx;
	logic signed [LEVEL_WIDTH-1:0] mid_peak_nx;
	logic signed [LEVEL_WIDTH-1:0] side_peak_nx;
	logic                          mid_floor_nx;
	logic                          side_floor_nx;

	// Configuration registers: every write lands at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_coeff <= lmb_pkg::RST_ATTACK;
			cfg_q.decay_coeff  <= lmb_pkg::RST_DECAY;
			cfg_q.floor_level  <= lmb_pkg::RST_FLOOR;
			cfg_q.hold_ticks   <= lmb_pkg::RST_HOLD;
			cfg_q.fall_step    <= lmb_pkg::RST_FALL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmb_pkg::CFG_ATTACK: cfg_q.attack_coeff <= cfg_data;
				lmb_pkg::CFG_DECAY:  cfg_q.decay_coeff  <= cfg_data;
				lmb_pkg::CFG_FLOOR:  cfg_q.floor_level  <= $signed(cfg_data);
				lmb_pkg::CFG_HOLD:   cfg_q.hold_ticks   <= cfg_data[7:0];
				lmb_pkg::CFG_FALL:   cfg_q.fall_step    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Advance stage 1 into the output register whenever that register frees up
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;
	assign fresh    = (packet_seq_s1 != prev_seq_q);
	assign upd      = adv && valid_s1 && fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the input transaction payload
	always_ff @(posedge clk) begin
		if (take) begin
			packet_seq_s1 <= packet_seq;
			mid_level_s1  <= mid_level;
			side_level_s1 <= side_level;
		end
	end

	// Remember the last new sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_q <= lmb_pkg::RST_SEQ;
		end else if (upd) begin
			prev_seq_q <= packet_seq_s1;
		end
	end

	lmb_channel #(
		.LEVEL_WIDTH      (LEVEL_WIDTH),
		.HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
	) u_mid (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.upd           (upd),
		.level         (mid_level_s1),
		.next_avg      (mid_avg_nx),
		.next_peak     (mid_peak_nx),
		.next_at_floor (mid_floor_nx)
	);

	lmb_channel #(
		.LEVEL_WIDTH      (LEVEL_WIDTH),
		.HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
	) u_side (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.upd           (upd),
		.level         (side_level_s1),
		.next_avg      (side_avg_nx),
		.next_peak     (side_peak_nx),
		.next_at_floor (side_floor_nx)
	);

	// Output register: take the stage 1 valid on advance, so the valid drops once the result completes and no packet waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			accepted      <= fresh;
			mid_smooth    <= mid_avg_nx;
			side_smooth   <= side_avg_nx;
			mid_peak_out  <= mid_peak_nx;
			side_peak_out <= side_peak_nx;
			mid_at_floor  <= mid_floor_nx;
			side_at_floor <= side_floor_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule
